@@ design/lsched_pkg.sv @@
// Shared types, sizes, codes and helper functions of the lottery scheduler.
// No dependencies; every other file of the block refers to it by scoped names.
package lsched_pkg;

   // Table sizing
   localparam int MAX_ENTRIES    = 16;
   localparam int ID_BITS        = 16;
   localparam int IDX_BITS       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
   localparam int TKT_BITS       = 8;
   localparam int TOTAL_BITS     = CNT_BITS + TKT_BITS;

   // Port field widths
   localparam int PID_BITS       = 16;
   localparam int PRIO_BITS      = 3;
   localparam int RND_BITS       = 31;
   localparam int RND_CNT_BITS   = $clog2(RND_BITS + 1);
   localparam int TOTAL_OUT_BITS = 12;
   localparam int CSR_IDX_BITS   = 3;

   // Opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_DRAW   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_DRAW   = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Priority codes
   localparam logic [PRIO_BITS-1:0] PRIO_VERY_LOW  = 3'd1;
   localparam logic [PRIO_BITS-1:0] PRIO_LOW       = 3'd2;
   localparam logic [PRIO_BITS-1:0] PRIO_MEDIUM    = 3'd3;
   localparam logic [PRIO_BITS-1:0] PRIO_HIGH      = 3'd4;
   localparam logic [PRIO_BITS-1:0] PRIO_VERY_HIGH = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKETS_VERY_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKETS_LOW       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKETS_MEDIUM    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKETS_HIGH      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKETS_VERY_HIGH = 3'd4;

   // Register reset values
   localparam logic [TKT_BITS-1:0] TKT_RESET_VERY_LOW  = 8'd1;
   localparam logic [TKT_BITS-1:0] TKT_RESET_LOW       = 8'd2;
   localparam logic [TKT_BITS-1:0] TKT_RESET_MEDIUM    = 8'd5;
   localparam logic [TKT_BITS-1:0] TKT_RESET_HIGH      = 8'd10;
   localparam logic [TKT_BITS-1:0] TKT_RESET_VERY_HIGH = 8'd20;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [TKT_BITS-1:0] tickets;
   } lsched_entry_type;

   typedef struct packed {
      logic                  start;
      logic [RND_BITS-1:0]   dividend;
      logic [TOTAL_BITS-1:0] divisor;
   } lsched_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [TOTAL_BITS-1:0] remainder;
   } lsched_div_rsp_type;

   // Port id to stored id: keep the low ID_BITS bits
   function automatic logic [ID_BITS-1:0] to_id(input logic [PID_BITS-1:0] pid);
      logic [ID_BITS+PID_BITS-1:0] w;
      w = (ID_BITS + PID_BITS)'(pid);
      return w[ID_BITS-1:0];
   endfunction

   // Stored id to port field
   function automatic logic [PID_BITS-1:0] to_pid(input logic [ID_BITS-1:0] id);
      logic [ID_BITS+PID_BITS-1:0] w;
      w = (ID_BITS + PID_BITS)'(id);
      return w[PID_BITS-1:0];
   endfunction

   // Saturate the internal total to the output field
   function automatic logic [TOTAL_OUT_BITS-1:0] sat_total(
      input logic [TOTAL_BITS-1:0] total);
      logic [TOTAL_BITS+TOTAL_OUT_BITS-1:0] w;
      w = (TOTAL_BITS + TOTAL_OUT_BITS)'(total);
      if (w > (TOTAL_BITS + TOTAL_OUT_BITS)'({TOTAL_OUT_BITS{1'b1}})) begin
         return {TOTAL_OUT_BITS{1'b1}};
      end
      return w[TOTAL_OUT_BITS-1:0];
   endfunction

endpackage

@@ design/lsched_mod_unit.sv @@
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on lsched_pkg for widths and the request/response structs.
module lsched_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  lsched_pkg::lsched_div_req_type div_req,
   output lsched_pkg::lsched_div_rsp_type div_rsp
);

   logic                                     busy_ff, busy_in;
   logic                                     done_ff, done_in;
   logic [lsched_pkg::RND_CNT_BITS-1:0]      step_ff, step_in;
   logic [lsched_pkg::RND_BITS-1:0]          dvd_ff, dvd_in;
   logic [lsched_pkg::TOTAL_BITS-1:0]        dsr_ff, dsr_in;
   logic [lsched_pkg::TOTAL_BITS-1:0]        rem_ff, rem_in;
   logic [lsched_pkg::TOTAL_BITS:0]          trial;
   logic [lsched_pkg::TOTAL_BITS:0]          trial_diff;
   logic [lsched_pkg::TOTAL_BITS-1:0]        rem_step;

   always_comb begin
      trial      = {rem_ff, dvd_ff[lsched_pkg::RND_BITS-1]};
      trial_diff = trial - {1'b0, dsr_ff};
      // trial stays below twice the divisor, so one subtract is enough
      if (trial >= {1'b0, dsr_ff}) begin
         rem_step = trial_diff[lsched_pkg::TOTAL_BITS-1:0];
      end else begin
         rem_step = trial[lsched_pkg::TOTAL_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = lsched_pkg::RND_CNT_BITS'(lsched_pkg::RND_BITS);
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_step;
         dvd_in  = {dvd_ff[lsched_pkg::RND_BITS-2:0], 1'b0};
         step_in = step_ff - lsched_pkg::RND_CNT_BITS'(1);
         if (step_ff == lsched_pkg::RND_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ design/lsched_entry_ram.sv @@
// Entry table memory: one write and one registered read per cycle.
// Depends on lsched_pkg for the entry type and table depth.
module lsched_entry_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [lsched_pkg::IDX_BITS-1:0]     wr_addr,
   input  lsched_pkg::lsched_entry_type        wr_data,
   input  logic [lsched_pkg::IDX_BITS-1:0]     rd_addr,
   output lsched_pkg::lsched_entry_type        rd_data
);

   lsched_pkg::lsched_entry_type mem_ff [lsched_pkg::MAX_ENTRIES];
   lsched_pkg::lsched_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lottery_scheduler_unit.sv @@
// Lottery scheduler top level: sequencer, ticket registers and result register.
// Depends on lsched_pkg, lsched_mod_unit and lsched_entry_ram.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  opcode, process id, priority, random value
//   rsp_     out        rsp_valid/rsp_stall  status, winner id, has entries, ticket total
//   csr_     in         csr_valid/csr_ready  register index, 8-bit ticket count
//
// Add and unknown opcodes finish at dispatch; remove runs a newest-first search,
// then copies each newer entry one slot down; draw runs the 31-step remainder
// unit, then walks entries newest-first via the one-read-per-cycle entry memory.
// Reset is synchronous and clears count, total and control; table contents are
// not cleared, only slots below the count are read. A stalled result is held in
// the output register; the next word is taken once the slot is free or draining.
module lottery_scheduler_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_opcode,
   input  logic [lsched_pkg::PID_BITS-1:0]          req_process_id,
   input  logic [lsched_pkg::PRIO_BITS-1:0]         req_priority_req,
   input  logic [lsched_pkg::RND_BITS-1:0]          req_random_value,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [lsched_pkg::PID_BITS-1:0]          rsp_winner_id,
   output logic                                     rsp_has_entries,
   output logic [lsched_pkg::TOTAL_OUT_BITS-1:0]    rsp_ticket_total,
   // configuration channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [lsched_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [lsched_pkg::TKT_BITS-1:0]          csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_FIND     = 6'b000100,
      ST_SHIFT    = 6'b001000,
      ST_DIV      = 6'b010000,
      ST_WALK     = 6'b100000
   } state_type;

   state_type                                state_ff, state_in;
   logic [lsched_pkg::CNT_BITS-1:0]          count_ff, count_in;
   logic [lsched_pkg::TOTAL_BITS-1:0]        total_ff, total_in;
   logic [lsched_pkg::IDX_BITS-1:0]          idx_ff, idx_in;
   logic [lsched_pkg::TOTAL_BITS-1:0]        sum_ff, sum_in;
   logic [lsched_pkg::TOTAL_BITS-1:0]        target_ff, target_in;
   logic [1:0]                               op_ff, op_in;
   logic [lsched_pkg::ID_BITS-1:0]           id_ff, id_in;
   logic [lsched_pkg::PRIO_BITS-1:0]         prio_ff, prio_in;
   logic [lsched_pkg::RND_BITS-1:0]          rnd_ff, rnd_in;

   logic [lsched_pkg::TKT_BITS-1:0]          tkt_very_low_ff, tkt_low_ff, tkt_medium_ff;
   logic [lsched_pkg::TKT_BITS-1:0]          tkt_high_ff, tkt_very_high_ff;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]                               rsp_status_ff, rsp_status_in;
   logic [lsched_pkg::PID_BITS-1:0]          rsp_winner_ff, rsp_winner_in;
   logic                                     rsp_has_ff, rsp_has_in;
   logic [lsched_pkg::TOTAL_OUT_BITS-1:0]    rsp_total_ff, rsp_total_in;

   logic                                     finish;
   logic [1:0]                               fin_status;
   logic [lsched_pkg::ID_BITS-1:0]           fin_winner;
   logic [lsched_pkg::TKT_BITS-1:0]          add_tickets;
   logic [lsched_pkg::CNT_BITS-1:0]          next_slot;
   logic [lsched_pkg::CNT_BITS-1:0]          skip_slot;
   logic [lsched_pkg::TOTAL_BITS-1:0]        sum_step;
   logic                                     req_accept;

   logic                                     ram_wr_en;
   logic [lsched_pkg::IDX_BITS-1:0]          ram_wr_addr;
   lsched_pkg::lsched_entry_type             ram_wr_data;
   logic [lsched_pkg::IDX_BITS-1:0]          ram_rd_addr;
   lsched_pkg::lsched_entry_type             ram_rd_data;

   lsched_pkg::lsched_div_req_type           div_req;
   lsched_pkg::lsched_div_rsp_type           div_rsp;

   lsched_mod_unit u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lsched_entry_ram u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Take a word only when idle and the result slot is free or draining
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      unique case (prio_ff)
         lsched_pkg::PRIO_VERY_LOW:  add_tickets = tkt_very_low_ff;
         lsched_pkg::PRIO_LOW:       add_tickets = tkt_low_ff;
         lsched_pkg::PRIO_MEDIUM:    add_tickets = tkt_medium_ff;
         lsched_pkg::PRIO_HIGH:      add_tickets = tkt_high_ff;
         lsched_pkg::PRIO_VERY_HIGH: add_tickets = tkt_very_high_ff;
         default:                    add_tickets = '0;
      endcase
   end

   assign next_slot = lsched_pkg::CNT_BITS'(idx_ff) + lsched_pkg::CNT_BITS'(1);
   assign skip_slot = lsched_pkg::CNT_BITS'(idx_ff) + lsched_pkg::CNT_BITS'(2);
   assign sum_step  = sum_ff + lsched_pkg::TOTAL_BITS'(ram_rd_data.tickets);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      total_in         = total_ff;
      idx_in           = idx_ff;
      sum_in           = sum_ff;
      target_in        = target_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      prio_in          = prio_ff;
      rnd_in           = rnd_ff;
      finish           = 1'b0;
      fin_status       = lsched_pkg::STATUS_OK;
      fin_winner       = '0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = idx_ff;
      ram_wr_data      = ram_rd_data;
      ram_rd_addr      = idx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rnd_ff;
      div_req.divisor  = total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_opcode;
               id_in    = lsched_pkg::to_id(req_process_id);
               prio_in  = req_priority_req;
               rnd_in   = req_random_value;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            unique case (op_ff)
               lsched_pkg::OP_ADD: begin
                  finish = 1'b1;
                  if (count_ff >= lsched_pkg::CNT_BITS'(lsched_pkg::MAX_ENTRIES)) begin
                     fin_status = lsched_pkg::STATUS_FULL;
                  end else begin
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = count_ff[lsched_pkg::IDX_BITS-1:0];
                     ram_wr_data.id      = id_ff;
                     ram_wr_data.tickets = add_tickets;
                     count_in = count_ff + lsched_pkg::CNT_BITS'(1);
                     total_in = total_ff + lsched_pkg::TOTAL_BITS'(add_tickets);
                  end
               end
               lsched_pkg::OP_REMOVE: begin
                  if (count_ff == '0) begin
                     finish     = 1'b1;
                     fin_status = lsched_pkg::STATUS_NOT_FOUND;
                  end else begin
                     idx_in      = lsched_pkg::IDX_BITS'(count_ff - lsched_pkg::CNT_BITS'(1));
                     ram_rd_addr = idx_in;
                     state_in    = ST_FIND;
                  end
               end
               lsched_pkg::OP_DRAW: begin
                  if (count_ff == '0 || total_ff == '0) begin
                     finish     = 1'b1;
                     fin_status = lsched_pkg::STATUS_NO_DRAW;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end

         ST_FIND: begin
            if (ram_rd_data.id == id_ff) begin
               total_in = total_ff - lsched_pkg::TOTAL_BITS'(ram_rd_data.tickets);
               if (next_slot < count_ff) begin
                  // close the gap: copy each newer entry one slot down
                  ram_rd_addr = next_slot[lsched_pkg::IDX_BITS-1:0];
                  state_in    = ST_SHIFT;
               end else begin
                  count_in = count_ff - lsched_pkg::CNT_BITS'(1);
                  finish   = 1'b1;
               end
            end else if (idx_ff == '0) begin
               finish     = 1'b1;
               fin_status = lsched_pkg::STATUS_NOT_FOUND;
            end else begin
               idx_in      = idx_ff - lsched_pkg::IDX_BITS'(1);
               ram_rd_addr = idx_in;
            end
         end

         ST_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            if (skip_slot < count_ff) begin
               idx_in      = idx_ff + lsched_pkg::IDX_BITS'(1);
               ram_rd_addr = skip_slot[lsched_pkg::IDX_BITS-1:0];
            end else begin
               count_in = count_ff - lsched_pkg::CNT_BITS'(1);
               finish   = 1'b1;
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               target_in   = div_rsp.remainder;
               sum_in      = '0;
               idx_in      = lsched_pkg::IDX_BITS'(count_ff - lsched_pkg::CNT_BITS'(1));
               ram_rd_addr = idx_in;
               state_in    = ST_WALK;
            end
         end

         ST_WALK: begin
            if (sum_step > target_ff) begin
               finish     = 1'b1;
               fin_winner = ram_rd_data.id;
            end else if (idx_ff == '0) begin
               finish     = 1'b1;
               fin_status = lsched_pkg::STATUS_NO_DRAW;
            end else begin
               sum_in      = sum_step;
               idx_in      = idx_ff - lsched_pkg::IDX_BITS'(1);
               ram_rd_addr = idx_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
   end

   // Result register: drop on take, load on finish
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_winner_in = rsp_winner_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_total_in  = rsp_total_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_winner_in = lsched_pkg::to_pid(fin_winner);
         rsp_has_in    = (count_in != '0);
         rsp_total_in  = lsched_pkg::sat_total(total_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      sum_ff        <= sum_in;
      target_ff     <= target_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      rnd_ff        <= rnd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // Ticket registers; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         tkt_very_low_ff  <= lsched_pkg::TKT_RESET_VERY_LOW;
         tkt_low_ff       <= lsched_pkg::TKT_RESET_LOW;
         tkt_medium_ff    <= lsched_pkg::TKT_RESET_MEDIUM;
         tkt_high_ff      <= lsched_pkg::TKT_RESET_HIGH;
         tkt_very_high_ff <= lsched_pkg::TKT_RESET_VERY_HIGH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lsched_pkg::CSR_TICKETS_VERY_LOW:  tkt_very_low_ff  <= csr_wdata;
            lsched_pkg::CSR_TICKETS_LOW:       tkt_low_ff       <= csr_wdata;
            lsched_pkg::CSR_TICKETS_MEDIUM:    tkt_medium_ff    <= csr_wdata;
            lsched_pkg::CSR_TICKETS_HIGH:      tkt_high_ff      <= csr_wdata;
            lsched_pkg::CSR_TICKETS_VERY_HIGH: tkt_very_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_winner_id    = rsp_winner_ff;
   assign rsp_has_entries  = rsp_has_ff;
   assign rsp_ticket_total = rsp_total_ff;

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_DISPATCH)
      else $error("accepted word did not reach dispatch");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lsched_pkg::CNT_BITS'(lsched_pkg::MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("remainder unit finished outside a draw");

   a_winner_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != lsched_pkg::STATUS_OK) |-> rsp_winner_ff == '0)
      else $error("winner id set on a failed request");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_total_ff == '0)
      else $error("empty table with non-zero ticket total");

endmodule
